// ----- rtl/knn_pkg.sv -----
`default_nettype none

package knn_pkg;

  localparam int LIST_DEPTH_DEF = 16;

  localparam int CMD_W   = 2;
  localparam int POS_W   = 16;
  localparam int TAG_W   = 16;
  localparam int DIST_W  = 34;
  localparam int STAT_W  = 3;
  localparam int SLOT_W  = 4;
  localparam int COUNT_W = 5;
  localparam int LIMIT_W = 5;

  localparam int MAX_READ = 16;

  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 64;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd10;

  localparam logic [CMD_W-1:0] CMD_START = 2'd0;
  localparam logic [CMD_W-1:0] CMD_OFFER = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  localparam logic [STAT_W-1:0] ST_STARTED   = 3'd0;
  localparam logic [STAT_W-1:0] ST_ACCEPTED  = 3'd1;
  localparam logic [STAT_W-1:0] ST_REJECTED  = 3'd2;
  localparam logic [STAT_W-1:0] ST_OUT_RANGE = 3'd3;
  localparam logic [STAT_W-1:0] ST_ENTRY     = 3'd4;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd5;

  typedef struct packed {
    logic              load_in;
    logic              load_query;
    logic              diff;
    logic              mul;
    logic              sum;
    logic              take;
    logic              sh_rd;
    logic              sh_wr;
    logic              fin_wr;
    logic              ro_init;
    logic              ro_rd;
    logic              ro_next;
    logic              out_load;
    logic [STAT_W-1:0] out_code;
  } dp_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             reject;
    logic             range_ok;
    logic             single;
    logic             pos_one;
    logic             d_lt_rd;
    logic             count_zero;
    logic             ro_last;
    logic             out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- rtl/knn_dpath.sv -----
`default_nettype none

module knn_dpath #(
  parameter int LIST_DEPTH = knn_pkg::LIST_DEPTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [knn_pkg::LIMIT_W-1:0]      cfg_wdata,
  input  wire logic [knn_pkg::IN_DATA_W-1:0]    in_tdata,
  input  wire logic [knn_pkg::CMD_W-1:0]        in_tuser,
  input  wire knn_pkg::dp_cmd_t                 cmd,
  output knn_pkg::dp_stat_t                     stat,
  input  wire logic                             out_tready,
  output logic                                  out_tvalid,
  output logic [knn_pkg::OUT_DATA_W-1:0]        out_tdata,
  output logic [knn_pkg::STAT_W-1:0]            out_tuser,
  output logic                                  out_tlast
);
  import knn_pkg::*;

  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int WW    = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  localparam logic [WW-1:0]    DEPTH_W  = WW'(LIST_DEPTH);
  localparam logic [WW-1:0]    READ_MAX = WW'(MAX_READ);
  localparam logic [CNT_W-1:0] ONE      = CNT_W'(1);

  logic [CMD_W-1:0]  cmd_r;
  logic [POS_W-1:0]  cand_x_r, cand_y_r;
  logic [TAG_W-1:0]  cand_grp_r, cand_id_r;
  logic [DIST_W-1:0] start_range_r;

  logic [POS_W-1:0]  query_x_r, query_y_r;
  logic [TAG_W-1:0]  query_grp_r, query_id_r;
  logic [DIST_W-1:0] range_r;
  logic [CNT_W-1:0]  count_r;
  logic [LIMIT_W-1:0] limit_r;

  logic signed [POS_W:0]     dx_r, dy_r;
  logic signed [2*POS_W+1:0] px, py;
  logic [2*POS_W-1:0]        sq_x_r, sq_y_r;
  logic [DIST_W-1:0]         d_r;

  logic [CNT_W-1:0]  pos_r, pos_dec, k_r;
  logic              first_r;
  logic [DIST_W-1:0] tail_r;

  logic [DIST_W-1:0] mem_dist [LIST_DEPTH];
  logic [TAG_W-1:0]  mem_id   [LIST_DEPTH];
  logic [DIST_W-1:0] rd_dist_r;
  logic [TAG_W-1:0]  rd_id_r;
  logic              rd_en, wr_en;
  logic [IDX_W-1:0]  rd_addr, wr_addr;
  logic [DIST_W-1:0] wr_dist;
  logic [TAG_W-1:0]  wr_id;

  logic [WW-1:0]     limit_ext, lim_w, read_n;
  logic [CNT_W-1:0]  lim, new_count;
  logic              ro_last;

  logic              out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [STAT_W-1:0] out_user_r;
  logic              out_last_r;
  logic [SLOT_W-1:0] o_slot;
  logic [TAG_W-1:0]  o_id;
  logic [DIST_W-1:0] o_dist;
  logic              o_last;

  // effective limit and read length
  assign limit_ext = WW'(limit_r);
  assign lim_w     = (limit_ext > DEPTH_W) ? DEPTH_W : limit_ext;
  assign lim       = CNT_W'(lim_w);
  assign new_count = (count_r < lim) ? count_r + ONE : count_r;
  assign read_n    = (WW'(count_r) > READ_MAX) ? READ_MAX : WW'(count_r);
  assign ro_last   = (WW'(k_r) + WW'(1)) == read_n;
  assign pos_dec   = pos_r - ONE;

  assign px = dx_r * dx_r;
  assign py = dy_r * dy_r;

  assign stat.cmd        = cmd_r;
  assign stat.reject     = (cand_id_r == query_id_r) || (cand_grp_r != query_grp_r);
  assign stat.range_ok   = (lim != '0) && (d_r < range_r);
  assign stat.single     = (new_count == ONE);
  assign stat.pos_one    = (pos_r == ONE);
  assign stat.d_lt_rd    = (d_r < rd_dist_r);
  assign stat.count_zero = (count_r == '0);
  assign stat.ro_last    = ro_last;
  assign stat.out_free   = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= LIMIT_RESET;
      query_x_r   <= '0;
      query_y_r   <= '0;
      query_grp_r <= '0;
      query_id_r  <= '0;
      range_r     <= '0;
      count_r     <= '0;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      if (cmd.load_query) begin
        query_x_r   <= cand_x_r;
        query_y_r   <= cand_y_r;
        query_grp_r <= cand_grp_r;
        query_id_r  <= cand_id_r;
        range_r     <= start_range_r;
        count_r     <= '0;
      end
      if (cmd.take) begin
        count_r <= new_count;
      end
      if (cmd.fin_wr && (count_r == lim)) begin
        range_r <= first_r ? d_r : tail_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cmd_r         <= in_tuser;
      cand_x_r      <= in_tdata[POS_W-1:0];
      cand_y_r      <= in_tdata[2*POS_W-1:POS_W];
      cand_grp_r    <= in_tdata[2*POS_W+TAG_W-1:2*POS_W];
      cand_id_r     <= in_tdata[2*POS_W+2*TAG_W-1:2*POS_W+TAG_W];
      start_range_r <= in_tdata[2*POS_W+2*TAG_W+DIST_W-1:2*POS_W+2*TAG_W];
    end
    if (cmd.diff) begin
      dx_r <= {cand_x_r[POS_W-1], cand_x_r} - {query_x_r[POS_W-1], query_x_r};
      dy_r <= {cand_y_r[POS_W-1], cand_y_r} - {query_y_r[POS_W-1], query_y_r};
    end
    if (cmd.mul) begin
      sq_x_r <= px[2*POS_W-1:0];
      sq_y_r <= py[2*POS_W-1:0];
    end
    if (cmd.sum) begin
      d_r <= DIST_W'(sq_x_r) + DIST_W'(sq_y_r);
    end
    if (cmd.take) begin
      pos_r   <= new_count - ONE;
      first_r <= 1'b1;
    end
    if (cmd.sh_wr) begin
      pos_r   <= pos_dec;
      first_r <= 1'b0;
      if (first_r) begin
        tail_r <= rd_dist_r;
      end
    end
    if (cmd.ro_init) begin
      k_r <= '0;
    end
    if (cmd.ro_next) begin
      k_r <= k_r + ONE;
    end
  end

  // neighbour list storage
  assign rd_en   = cmd.sh_rd || cmd.ro_rd;
  assign rd_addr = cmd.sh_rd ? pos_dec[IDX_W-1:0] : k_r[IDX_W-1:0];
  assign wr_en   = cmd.sh_wr || cmd.fin_wr;
  assign wr_addr = pos_r[IDX_W-1:0];
  assign wr_dist = cmd.sh_wr ? rd_dist_r : d_r;
  assign wr_id   = cmd.sh_wr ? rd_id_r : cand_id_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_dist[wr_addr] <= wr_dist;
      mem_id[wr_addr]   <= wr_id;
    end
    if (rd_en) begin
      rd_dist_r <= mem_dist[rd_addr];
      rd_id_r   <= mem_id[rd_addr];
    end
  end

  // result fields by status
  always_comb begin
    o_slot = '0;
    o_id   = '0;
    o_dist = '0;
    o_last = 1'b1;
    case (cmd.out_code)
      ST_ACCEPTED: begin
        o_slot = SLOT_W'(pos_r);
        o_dist = d_r;
      end
      ST_OUT_RANGE: begin
        o_dist = d_r;
      end
      ST_ENTRY: begin
        o_slot = SLOT_W'(k_r);
        o_id   = rd_id_r;
        o_dist = rd_dist_r;
        o_last = ro_last;
      end
      default: begin
        o_last = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= OUT_DATA_W'({COUNT_W'(count_r), o_dist, o_id, o_slot});
      out_user_r <= cmd.out_code;
      out_last_r <= o_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

// ----- rtl/knn_ctrl.sv -----
`default_nettype none

module knn_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire knn_pkg::dp_stat_t stat,
  output knn_pkg::dp_cmd_t       cmd
);
  import knn_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DECODE  = 4'd1;
  localparam logic [3:0] S_DIFF    = 4'd2;
  localparam logic [3:0] S_MUL     = 4'd3;
  localparam logic [3:0] S_SUM     = 4'd4;
  localparam logic [3:0] S_TEST    = 4'd5;
  localparam logic [3:0] S_SH_RD   = 4'd6;
  localparam logic [3:0] S_SH_CMP  = 4'd7;
  localparam logic [3:0] S_WR      = 4'd8;
  localparam logic [3:0] S_EMIT    = 4'd9;
  localparam logic [3:0] S_RO_RD   = 4'd10;
  localparam logic [3:0] S_RO_EMIT = 4'd11;

  logic [3:0]        state_r, state_nxt;
  logic [STAT_W-1:0] code_r, code_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      code_r  <= ST_STARTED;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    code_nxt     = code_r;
    cmd          = '0;
    cmd.out_code = code_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.cmd)
          CMD_START: begin
            cmd.load_query = 1'b1;
            code_nxt       = ST_STARTED;
            state_nxt      = S_EMIT;
          end
          CMD_OFFER: begin
            if (stat.reject) begin
              code_nxt  = ST_REJECTED;
              state_nxt = S_EMIT;
            end else begin
              cmd.diff  = 1'b1;
              state_nxt = S_DIFF;
            end
          end
          CMD_READ: begin
            if (stat.count_zero) begin
              code_nxt  = ST_EMPTY;
              state_nxt = S_EMIT;
            end else begin
              cmd.ro_init = 1'b1;
              state_nxt   = S_RO_RD;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_DIFF: begin
        cmd.mul   = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.sum   = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        state_nxt = S_TEST;
      end
      S_TEST: begin
        if (!stat.range_ok) begin
          code_nxt  = ST_OUT_RANGE;
          state_nxt = S_EMIT;
        end else begin
          cmd.take  = 1'b1;
          state_nxt = stat.single ? S_WR : S_SH_RD;
        end
      end
      S_SH_RD: begin
        cmd.sh_rd = 1'b1;
        state_nxt = S_SH_CMP;
      end
      S_SH_CMP: begin
        if (stat.d_lt_rd) begin
          cmd.sh_wr = 1'b1;
          state_nxt = stat.pos_one ? S_WR : S_SH_RD;
        end else begin
          state_nxt = S_WR;
        end
      end
      S_WR: begin
        cmd.fin_wr = 1'b1;
        code_nxt   = ST_ACCEPTED;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_RO_RD: begin
        cmd.ro_rd = 1'b1;
        state_nxt = S_RO_EMIT;
      end
      S_RO_EMIT: begin
        cmd.out_code = ST_ENTRY;
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          if (stat.ro_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.ro_next = 1'b1;
            state_nxt   = S_RO_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/k_nearest_neighbour_insert.sv -----
// Bounded nearest-neighbour list for one query point.
// Input stream: in_tuser carries the command (start, offer candidate, read out),
// in_tdata the position, group, id and start range. Output stream: out_tuser is
// the status, out_tdata slot, id, distance and count, out_tlast marks the final
// result of an item. cfg_we/cfg_wdata set the neighbour limit (reset value 10).
// Items are taken one at a time, in_tready is high only while the block is idle.
// Per item: start, rejected candidate and empty read each give one result,
// an unused command gives no result, a candidate out of range or with limit
// zero gives one, and a candidate in range gives one after it is compared with
// list entries on the way down (each entry moved, plus the one it stops behind
// unless it reaches slot 0). A read out emits one result per entry (at most 16).
// The insertion walks the list one entry at a time, reading then comparing
// each, over the single read port of the list memory; the distance goes
// through a subtract, a square and a sum stage before the range test.
// A held result on out_tvalid does not block acceptance of the next item; the
// block stalls only where it must load a new result while out_tready is low.
// Synchronous reset empties the list, clears query and range, and drops any
// pending result; list memory needs no clearing since only filled slots are read.
`default_nettype none

module k_nearest_neighbour_insert #(
  parameter int LIST_DEPTH = knn_pkg::LIST_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [knn_pkg::LIMIT_W-1:0]   cfg_wdata,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // pos_x, pos_y, group_tag, agent_id, start_range_sq
  input  wire logic [knn_pkg::IN_DATA_W-1:0] in_tdata,
  // command
  input  wire logic [knn_pkg::CMD_W-1:0]     in_tuser,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // slot, neighbour_id, neighbour_dist_sq, count
  output logic [knn_pkg::OUT_DATA_W-1:0]     out_tdata,
  // status
  output logic [knn_pkg::STAT_W-1:0]         out_tuser,
  output logic                               out_tlast
);
  import knn_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  knn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  knn_dpath #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .stat       (stat),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

// ----- rtl/knn_checker.sv -----
`default_nettype none

module knn_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_tvalid,
  input wire logic                          in_tready,
  input wire logic                          out_tvalid,
  input wire logic                          out_tready,
  input wire logic [knn_pkg::OUT_DATA_W-1:0] out_tdata,
  input wire logic [knn_pkg::STAT_W-1:0]     out_tuser,
  input wire logic                          out_tlast
);
  import knn_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("not idle after reset");

  a_started: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_STARTED) |-> out_tlast && (out_tdata[58:54] == '0))
    else $error("start result with nonzero count");

  a_accepted: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_ACCEPTED) |-> out_tlast && (out_tdata[58:54] != '0))
    else $error("accepted result with empty list");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while busy");

endmodule

bind k_nearest_neighbour_insert knn_checker u_knn_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire
